### hw/rtl/mouse_packet_position_tracker_macros.svh
// assertion macros used by the checker file
`ifndef MOUSE_PACKET_POSITION_TRACKER_MACROS_SVH
`define MOUSE_PACKET_POSITION_TRACKER_MACROS_SVH

// clocked property, switched off while reset is high
`define MPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset as well
`define MPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mpt_pkg.sv
// shared types and constants of the mouse packet position tracker
`default_nettype none

package mpt_pkg;

   // coordinate and field widths
   localparam int COORD_BITS  = 12;
   localparam int SCREEN_BITS = 12;
   localparam int CURSOR_BITS = 12;
   localparam int BYTE_BITS   = 8;
   localparam int DELTA_BITS  = BYTE_BITS + 1;
   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int SUM_BITS    = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 2;

   // bit positions in the flags byte
   localparam int SYNC_BIT  = 3;
   localparam int X_OVF_BIT = 6;
   localparam int Y_OVF_BIT = 7;
   localparam int LEFT_BIT  = 0;

   // screen defaults, also used when a size register holds zero
   localparam logic [SCREEN_BITS-1:0] DEFAULT_WIDTH  = SCREEN_BITS'(800);
   localparam logic [SCREEN_BITS-1:0] DEFAULT_HEIGHT = SCREEN_BITS'(600);

   // home position after reset, limited to the coordinate range
   localparam logic [COORD_BITS-1:0] HOME_X = COORD_BITS'((400 > COORD_MAX) ? COORD_MAX : 400);
   localparam logic [COORD_BITS-1:0] HOME_Y = COORD_BITS'((300 > COORD_MAX) ? COORD_MAX : 300);

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_LSB   = 2;
   localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
   localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic [SCREEN_BITS-1:0] screen_width;
      logic [SCREEN_BITS-1:0] screen_height;
   } cfg_type;

   // position inside the three byte packet
   typedef enum logic [1:0] {
      IDX_FLAGS = 2'd0,
      IDX_DX    = 2'd1,
      IDX_DY    = 2'd2
   } idx_type;

endpackage

`default_nettype wire

### hw/rtl/mpt_csr.sv
// screen size registers behind the apb-style port
`default_nettype none

module mpt_csr
   import mpt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output cfg_type                       cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [0:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[REG_IDX_LSB];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[SCREEN_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[SCREEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SCREEN_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.screen_height);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= DEFAULT_WIDTH;
         cfg_ff.screen_height <= DEFAULT_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/mpt_clamp.sv
// one axis: add the delta and clamp to the screen and coordinate range
`default_nettype none

module mpt_clamp
   import mpt_pkg::*;
(
   input  wire logic        [COORD_BITS-1:0]  pos,
   input  wire logic signed [DELTA_BITS-1:0]  delta,
   input  wire logic        [SCREEN_BITS-1:0] size,
   input  wire logic        [SCREEN_BITS-1:0] fallback,
   output logic             [COORD_BITS-1:0]  pos_next
);

   localparam logic signed [SUM_BITS-1:0] COORD_MAX_S = SUM_BITS'(COORD_MAX);

   logic signed [SUM_BITS-1:0]    sum;
   logic signed [SUM_BITS-1:0]    top_raw;
   logic signed [SUM_BITS-1:0]    top;
   logic        [SCREEN_BITS-1:0] size_eff;

   // zero size falls back to the default screen
   assign size_eff = (size == '0) ? fallback : size;
   assign top_raw  = $signed({{(SUM_BITS-SCREEN_BITS){1'b0}}, size_eff}) - SUM_BITS'(1);
   assign top      = (top_raw > COORD_MAX_S) ? COORD_MAX_S : top_raw;

   assign sum = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, pos})
              + $signed({{(SUM_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta});

   always_comb begin
      priority if (sum < 0) begin
         pos_next = '0;
      end else if (sum > top) begin
         pos_next = top[COORD_BITS-1:0];
      end else begin
         pos_next = sum[COORD_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/mouse_packet_position_tracker.sv
// top level: ps/2 byte stream to clamped cursor position
// path: an accepted byte is held in the input register, and the third byte's result
//   is then registered in the result register that drives rsp_*
// throughput: one byte per cycle unless a finished result is stalled downstream; the
//   position add and clamp are combinational between the input and position registers
// reset (synchronous, active high): empty pipeline, waiting for a flags byte,
//   cursor at (400,300), screen size 800 x 600
`default_nettype none

module mouse_packet_position_tracker
   import mpt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // byte input channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [BYTE_BITS-1:0]     req_rx_byte,
   // position result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [CURSOR_BITS-1:0]   rsp_cursor_x,
   output logic      [CURSOR_BITS-1:0]   rsp_cursor_y,
   output logic                          rsp_left_pressed,
   // register port
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   cfg_type cfg;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]  in_byte_ff;
   // packet assembly state
   idx_type               idx_ff, idx_in;
   logic [BYTE_BITS-1:0]  flags_ff;
   logic [BYTE_BITS-1:0]  dx_ff;
   // kept cursor position
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] cur_x_ff;
   logic [COORD_BITS-1:0] cur_y_ff;
   logic                  left_ff;

   logic                  out_free;
   logic                  take_byte;
   logic                  accept_in;
   logic                  save_flags;
   logic                  save_dx;
   logic                  emit;
   logic signed [DELTA_BITS-1:0] delta_x;
   logic signed [DELTA_BITS-1:0] delta_y;

   mpt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: the held byte moves on whenever the result register can take a result,
   // so a new byte enters every cycle unless a finished result is stalled downstream
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign take_byte = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept_in = req_valid && !req_stall;

   assign in_valid_in = accept_in || (in_valid_ff && !take_byte);

   // deltas: x sign-extended, y sign-extended then negated so down is positive
   assign delta_x = $signed({dx_ff[BYTE_BITS-1], dx_ff});
   assign delta_y = -$signed({in_byte_ff[BYTE_BITS-1], in_byte_ff});

   mpt_clamp u_clamp_x (
      .pos      (pos_x_ff),
      .delta    (delta_x),
      .size     (cfg.screen_width),
      .fallback (DEFAULT_WIDTH),
      .pos_next (pos_x_in)
   );

   mpt_clamp u_clamp_y (
      .pos      (pos_y_ff),
      .delta    (delta_y),
      .size     (cfg.screen_height),
      .fallback (DEFAULT_HEIGHT),
      .pos_next (pos_y_in)
   );

   // packet sequencer
   always_comb begin
      idx_in     = idx_ff;
      save_flags = 1'b0;
      save_dx    = 1'b0;
      emit       = 1'b0;
      if (take_byte) begin
         unique case (idx_ff)
            IDX_FLAGS: begin
               // resync: only a byte with the sync bit can open a packet
               if (in_byte_ff[SYNC_BIT]) begin
                  save_flags = 1'b1;
                  idx_in     = IDX_DX;
               end
            end
            IDX_DX: begin
               save_dx = 1'b1;
               idx_in  = IDX_DY;
            end
            IDX_DY: begin
               idx_in = IDX_FLAGS;
               // overflow packets are dropped without moving the cursor
               emit   = !(flags_ff[X_OVF_BIT] || flags_ff[Y_OVF_BIT]);
            end
            default: begin
               idx_in = IDX_FLAGS;
            end
         endcase
      end
   end

   // result stays until taken, or is replaced in the same cycle it is taken
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= IDX_FLAGS;
         pos_x_ff     <= HOME_X;
         pos_y_ff     <= HOME_Y;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_byte_ff <= req_rx_byte;
      end
      if (save_flags) begin
         flags_ff <= in_byte_ff;
      end
      if (save_dx) begin
         dx_ff <= in_byte_ff;
      end
      if (emit) begin
         cur_x_ff <= pos_x_in;
         cur_y_ff <= pos_y_in;
         left_ff  <= flags_ff[LEFT_BIT];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_x     = CURSOR_BITS'(cur_x_ff);
   assign rsp_cursor_y     = CURSOR_BITS'(cur_y_ff);
   assign rsp_left_pressed = left_ff;

endmodule

`default_nettype wire

### hw/rtl/mpt_checker.sv
// port-level checks of the tracker, bound to the top level
`default_nettype none
`include "mouse_packet_position_tracker_macros.svh"

module mpt_checker
   import mpt_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [CURSOR_BITS-1:0]   rsp_cursor_x,
   input wire logic [CURSOR_BITS-1:0]   rsp_cursor_y,
   input wire logic                     rsp_left_pressed
);

   // a stalled result holds its position and button
   `MPT_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_cursor_x) && $stable(rsp_cursor_y) && $stable(rsp_left_pressed)), "stalled result changed")

   // no result right after reset
   `MPT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // a fresh result follows a byte that was accepted and then held in the input register
   `MPT_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "result without a byte behind it")

   // clamped to at most size minus one, so never all ones
   `MPT_ASSERT(a_pos_range, clock, reset, rsp_valid |-> (rsp_cursor_x != '1 && rsp_cursor_y != '1), "cursor beyond largest screen")

endmodule

bind mouse_packet_position_tracker mpt_checker u_mpt_checker (.*);

`default_nettype wire
